FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during rst
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/mf3x3_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mf3x3_pkg
// Types and constants of the 3x3 median filter.
// ---------------------------------------------------------------------------
package mf3x3_pkg;

  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 12;
  localparam int CFG_W    = 12;
  localparam int POS_W    = 13;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic [WIDTH_W-1:0]  WIDTH_MIN  = 11'd3;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = 12'd3;

  // pixels within this many rows or columns of the frame edge pass through
  localparam logic [POS_W-1:0] BORDER = 13'd2;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int CNT_W      = 4;

  typedef struct packed {
    logic       op;
    logic [7:0] pixel_in;
  } req_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       frame_last;
  } rsp_t;

  // one column entry of the line stores: a = row above, b = two rows above
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
  } line_t;

  typedef logic [2:0][2:0][7:0] win_t;

  typedef struct packed {
    logic has_result;
    logic border;
    logic last;
  } tag_t;

endpackage

FILE: sv/median_filter_3x3.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// median_filter_3x3
// 3x3 median filter over a raster pixel stream with two line stores.
// ---------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------
//  req     | req_valid / req_ready | op, pixel_in
//  rsp     | rsp_valid / rsp_ready | pixel_out, frame_last
//  cfg     | cfg_we (no wait)      | cfg_index, cfg_data
//
//  One request per cycle while req_ready is high; a result reaches rsp through
//  the line store read, window, two sort stages and the result queue. After rst
//  the line stores are swept to zero with req_ready low. An eight-entry result
//  queue absorbs rsp stalls; apart from the sweep, req_ready drops only when
//  queued plus in-flight results fill it.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module median_filter_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  mf3x3_pkg::req_t               req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output mf3x3_pkg::rsp_t               rsp,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [mf3x3_pkg::CFG_W-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam logic [mf3x3_pkg::POS_W-1:0] MAXW = mf3x3_pkg::POS_W'(MAX_WIDTH);

  // configuration, stored already clamped
  logic [mf3x3_pkg::WIDTH_W-1:0]  img_w;
  logic [mf3x3_pkg::HEIGHT_W-1:0] img_h;
  logic [mf3x3_pkg::WIDTH_W-1:0]  cfg_w;

  // position and fill state
  logic [CW-1:0]                  col, col_next;
  logic [mf3x3_pkg::HEIGHT_W-1:0] row, row_next;
  logic [mf3x3_pkg::HEIGHT_W-1:0] pending, pending_next;
  logic [mf3x3_pkg::HEIGHT_W-1:0] pend_full, pend_eff;

  logic [mf3x3_pkg::POS_W-1:0] col_x, row_x, w_x, h_x, ocol, orow_raw, orow;
  logic                        acc, is_flush, adv, has_res, drain_done;
  logic [7:0]                  p;
  mf3x3_pkg::tag_t             tag0;

  // pipeline
  logic                  s1_valid, s2_valid;
  logic [CW-1:0]         s1_col;
  logic [7:0]            s1_p;
  mf3x3_pkg::tag_t       s1_tag, s2_tag;
  mf3x3_pkg::win_t       window;
  mf3x3_pkg::line_t      rd_data, wr_data;
  logic                  busy;

  logic                         med_push;
  mf3x3_pkg::rsp_t              med_rsp;
  logic [mf3x3_pkg::CNT_W-1:0]  inflight, fifo_count;
  logic [mf3x3_pkg::CNT_W:0]    credit;

  // configuration writes
  always_comb begin
    if (cfg_data[mf3x3_pkg::WIDTH_W-1:0] < mf3x3_pkg::WIDTH_MIN) begin
      cfg_w = mf3x3_pkg::WIDTH_MIN;
    end else if (mf3x3_pkg::POS_W'(cfg_data[mf3x3_pkg::WIDTH_W-1:0]) > MAXW) begin
      cfg_w = mf3x3_pkg::WIDTH_W'(MAX_WIDTH);
    end else begin
      cfg_w = cfg_data[mf3x3_pkg::WIDTH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= mf3x3_pkg::WIDTH_RST;
      img_h <= mf3x3_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mf3x3_pkg::REG_WIDTH: begin
          img_w <= cfg_w;
        end
        mf3x3_pkg::REG_HEIGHT: begin
          img_h <= (cfg_data < mf3x3_pkg::HEIGHT_MIN) ? mf3x3_pkg::HEIGHT_MIN : cfg_data;
        end
      endcase
    end
  end

  // request decode and output position
  assign acc       = req_valid && req_ready;
  assign is_flush  = (req.op == mf3x3_pkg::OP_FLUSH);
  assign pend_full = mf3x3_pkg::HEIGHT_W'(img_w) + 1'b1;
  assign pend_eff  = (pending > pend_full) ? pend_full : pending;
  assign adv       = !is_flush || (pending != '0);
  assign has_res   = is_flush ? (pending != '0) : (pending >= pend_full);
  assign p         = is_flush ? 8'd0 : req.pixel_in;
  assign drain_done = is_flush && (pend_eff == 12'd1);

  assign col_x = mf3x3_pkg::POS_W'(col);
  assign row_x = mf3x3_pkg::POS_W'(row);
  assign w_x   = mf3x3_pkg::POS_W'(img_w);
  assign h_x   = mf3x3_pkg::POS_W'(img_h);

  // the result is the window centre, one line plus one pixel behind
  assign ocol     = (col != '0) ? col_x - 1'b1 : w_x - 1'b1;
  assign orow_raw = (col != '0) ? row_x - 13'd1 : row_x - 13'd2;
  assign orow     = orow_raw[mf3x3_pkg::POS_W-1] ? orow_raw + h_x : orow_raw;

  always_comb begin
    tag0.has_result = has_res;
    tag0.border     = (orow < mf3x3_pkg::BORDER) || (orow + mf3x3_pkg::BORDER >= h_x) ||
                      (ocol < mf3x3_pkg::BORDER) || (ocol + mf3x3_pkg::BORDER >= w_x);
    tag0.last       = (orow == h_x - 1'b1) && (ocol == w_x - 1'b1);
  end

  always_comb begin
    col_next = col;
    row_next = row;
    if (col_x + 1'b1 >= w_x) begin
      col_next = '0;
      row_next = (row_x + 1'b1 >= h_x) ? '0 : row + 1'b1;
    end else begin
      col_next = col + 1'b1;
    end
    if (drain_done) begin
      col_next = '0;
      row_next = '0;
    end
    if (is_flush) begin
      pending_next = (pending == '0) ? pending : pend_eff - 1'b1;
    end else begin
      pending_next = has_res ? pend_full : pending + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      pending <= '0;
    end else if (acc) begin
      pending <= pending_next;
      if (adv) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

  // stage 1: line store data arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= acc && adv;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_col <= col;
    s1_p   <= p;
    s1_tag <= tag0;
    s2_tag <= s1_tag;
  end

  always_comb begin
    wr_data.a = s1_p;
    wr_data.b = rd_data.a;
  end

  mf3x3_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .rst     (rst),
    .busy    (busy),
    .rd_en   (acc && adv),
    .rd_addr (col),
    .rd_data (rd_data),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data (wr_data)
  );

  // stage 2: shift the window by one column
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        window[r][0] <= window[r][1];
        window[r][1] <= window[r][2];
      end
      window[0][2] <= rd_data.b;
      window[1][2] <= rd_data.a;
      window[2][2] <= s1_p;
    end
  end

  mf3x3_median u_median (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s2_valid),
    .win      (window),
    .tag      (s2_tag),
    .push     (med_push),
    .result   (med_rsp)
  );

  mf3x3_out_fifo u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (med_push),
    .din   (med_rsp),
    .pop   (rsp_valid && rsp_ready),
    .dout  (rsp),
    .valid (rsp_valid),
    .count (fifo_count)
  );

  // results promised but not yet queued
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (acc && has_res && !med_push) begin
      inflight <= inflight + 1'b1;
    end else if (med_push && !(acc && has_res)) begin
      inflight <= inflight - 1'b1;
    end
  end

  assign credit    = (mf3x3_pkg::CNT_W+1)'(inflight) + (mf3x3_pkg::CNT_W+1)'(fifo_count);
  assign req_ready = !busy && (credit < (mf3x3_pkg::CNT_W+1)'(mf3x3_pkg::FIFO_DEPTH));

  `ASSERT_IMPL(a_credit_bound, 1'b1, credit <= (mf3x3_pkg::CNT_W+1)'(mf3x3_pkg::FIFO_DEPTH))
  `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
  `ASSERT_NEXT(a_idle_flush, acc && is_flush && (pending == '0), !s1_valid)

endmodule

FILE: sv/mf3x3_line_buf.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mf3x3_line_buf
// Two line stores packed in one memory, registered read, write-to-read bypass
// and a zero sweep after reset.
// ---------------------------------------------------------------------------
module mf3x3_line_buf #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  output logic                     busy,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output mf3x3_pkg::line_t         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  mf3x3_pkg::line_t         wr_data
);

  localparam int AW = $clog2(DEPTH);

  mf3x3_pkg::line_t mem [DEPTH];
  mf3x3_pkg::line_t mem_q;
  mf3x3_pkg::line_t byp_data;
  logic             byp;
  logic             clearing;
  logic [AW-1:0]    clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      byp_data <= wr_data;
    end
  end

  // same column written in the cycle it is read: take the new entry
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (rd_en) begin
      byp <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp ? byp_data : mem_q;
  assign busy    = clearing;

endmodule

FILE: sv/mf3x3_median.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mf3x3_median
// Two-stage median of nine: column sort, then max/med/min merge.
// ---------------------------------------------------------------------------
module mf3x3_median (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  mf3x3_pkg::win_t    win,
  input  mf3x3_pkg::tag_t    tag,
  output logic               push,
  output mf3x3_pkg::rsp_t    result
);

  function automatic logic [7:0] min2(input logic [7:0] x, input logic [7:0] y);
    return (x < y) ? x : y;
  endfunction

  function automatic logic [7:0] max2(input logic [7:0] x, input logic [7:0] y);
    return (x < y) ? y : x;
  endfunction

  function automatic logic [7:0] med3(input logic [7:0] x, input logic [7:0] y,
                                      input logic [7:0] z);
    return max2(min2(x, y), min2(max2(x, y), z));
  endfunction

  logic [2:0][7:0] lo, mid, hi;
  logic [2:0][7:0] lo_next, mid_next, hi_next;
  logic [7:0]      centre_a;
  mf3x3_pkg::tag_t tag_a;
  logic            valid_a;
  logic [7:0]      lo_max, mid_med, hi_min, med;

  // sort each window column
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lo_next[c]  = min2(min2(win[0][c], win[1][c]), win[2][c]);
      hi_next[c]  = max2(max2(win[0][c], win[1][c]), win[2][c]);
      mid_next[c] = med3(win[0][c], win[1][c], win[2][c]);
    end
  end

  always_ff @(posedge clk) begin
    lo       <= lo_next;
    mid      <= mid_next;
    hi       <= hi_next;
    centre_a <= win[1][1];
    tag_a    <= tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      push    <= 1'b0;
    end else begin
      valid_a <= in_valid;
      push    <= valid_a && tag_a.has_result;
    end
  end

  assign lo_max  = max2(max2(lo[0], lo[1]), lo[2]);
  assign hi_min  = min2(min2(hi[0], hi[1]), hi[2]);
  assign mid_med = med3(mid[0], mid[1], mid[2]);
  assign med     = med3(lo_max, mid_med, hi_min);

  always_ff @(posedge clk) begin
    result.pixel_out  <= tag_a.border ? centre_a : med;
    result.frame_last <= tag_a.last;
  end

endmodule

FILE: sv/mf3x3_out_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mf3x3_out_fifo
// Small result queue that decouples the filter pipeline from the consumer.
// ---------------------------------------------------------------------------
module mf3x3_out_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  mf3x3_pkg::rsp_t              din,
  input  logic                         pop,
  output mf3x3_pkg::rsp_t              dout,
  output logic                         valid,
  output logic [mf3x3_pkg::CNT_W-1:0]  count
);

  mf3x3_pkg::rsp_t                     slots [mf3x3_pkg::FIFO_DEPTH];
  logic [mf3x3_pkg::FIFO_AW-1:0]       wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign dout  = slots[rd_ptr];
  assign valid = (count != '0);

endmodule

FILE: tb/median_filter_3x3_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// median_filter_3x3_checker
// Watches the request, result and register ports of the median filter,
// predicts every result from its own copy of the line stores, window and
// raster counters, and compares each result field by field, in order.
// ---------------------------------------------------------------------------
module median_filter_3x3_checker #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic                        req_ready,
  input  mf3x3_pkg::req_t             req,
  input  logic                        rsp_valid,
  input  logic                        rsp_ready,
  input  mf3x3_pkg::rsp_t             rsp,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [mf3x3_pkg::CFG_W-1:0] cfg_data,
  output int                          mismatch_count,
  output int                          results_owed
);

  logic [mf3x3_pkg::WIDTH_W-1:0]  width_reg;
  logic [mf3x3_pkg::HEIGHT_W-1:0] height_reg;
  logic [7:0]          row_above  [MAX_WIDTH];
  logic [7:0]          row_above2 [MAX_WIDTH];
  logic [7:0]          win [3][3];
  int                  col_pos;
  int                  row_pos;
  int                  backlog;
  int                  mismatches;
  mf3x3_pkg::rsp_t     expected_pixels [$];

  function automatic int eff_width();
    if (width_reg < mf3x3_pkg::WIDTH_MIN) return int'(mf3x3_pkg::WIDTH_MIN);
    if (int'(width_reg) > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    return (height_reg < mf3x3_pkg::HEIGHT_MIN) ? int'(mf3x3_pkg::HEIGHT_MIN) :
                                                  int'(height_reg);
  endfunction

  function automatic logic [7:0] median_of_window();
    logic [7:0] v [9];
    logic [7:0] x;
    int         j;
    for (int i = 0; i < 9; i++) v[i] = win[i / 3][i % 3];
    for (int i = 1; i < 9; i++) begin
      x = v[i];
      j = i - 1;
      while (j >= 0 && v[j] > x) begin
        v[j + 1] = v[j];
        j--;
      end
      v[j + 1] = x;
    end
    return v[4];
  endfunction

  // Shift one value into the line stores and window; give the centre result.
  task automatic slide_window(input logic [7:0] p, output mf3x3_pkg::rsp_t res);
    int         w;
    int         h;
    int         orow;
    int         ocol;
    logic [7:0] up1;
    logic [7:0] up2;
    logic       on_border;
    w   = eff_width();
    h   = eff_height();
    up1 = 8'd0;
    up2 = 8'd0;
    if (col_pos < MAX_WIDTH) begin
      up1 = row_above[col_pos];
      up2 = row_above2[col_pos];
      row_above2[col_pos] = up1;
      row_above[col_pos]  = p;
    end
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up2;
    win[1][2] = up1;
    win[2][2] = p;
    // centre sits one line plus one pixel behind the incoming position
    if (col_pos >= 1) begin
      ocol = col_pos - 1;
      orow = row_pos - 1;
    end else begin
      ocol = w - 1;
      orow = row_pos - 2;
    end
    if (orow < 0) orow += h;
    on_border = orow < int'(mf3x3_pkg::BORDER) || orow + int'(mf3x3_pkg::BORDER) >= h ||
                ocol < int'(mf3x3_pkg::BORDER) || ocol + int'(mf3x3_pkg::BORDER) >= w;
    res.pixel_out  = on_border ? win[1][1] : median_of_window();
    res.frame_last = (orow == h - 1) && (ocol == w - 1);
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  task automatic predict_request(input mf3x3_pkg::req_t r);
    int              full;
    mf3x3_pkg::rsp_t res;
    full = eff_width() + 1;
    if (r.op == mf3x3_pkg::OP_PIXEL) begin
      slide_window(r.pixel_in, res);
      if (backlog >= full) begin
        backlog = full;
        expected_pixels.push_back(res);
      end else begin
        backlog++;
      end
    end else if (backlog != 0) begin
      // flush: push a zero and drain one owed result
      if (backlog > full) backlog = full;
      slide_window(8'd0, res);
      backlog--;
      if (backlog == 0) begin
        col_pos = 0;
        row_pos = 0;
      end
      expected_pixels.push_back(res);
    end
  endtask

  always @(posedge clk) begin : watch
    mf3x3_pkg::rsp_t want;
    if (rst) begin
      width_reg  = mf3x3_pkg::WIDTH_RST;
      height_reg = mf3x3_pkg::HEIGHT_RST;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_above[i]  = 8'd0;
        row_above2[i] = 8'd0;
      end
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) win[r][c] = 8'd0;
      col_pos    = 0;
      row_pos    = 0;
      backlog    = 0;
      mismatches = 0;
      expected_pixels.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got pixel_out=%0d frame_last=%0b",
                   $time, rsp.pixel_out, rsp.frame_last);
        end else begin
          want = expected_pixels.pop_front();
          if (rsp.pixel_out !== want.pixel_out) begin
            mismatches++;
            $display("%0t: pixel_out expected %0d, got %0d",
                     $time, want.pixel_out, rsp.pixel_out);
          end
          if (rsp.frame_last !== want.frame_last) begin
            mismatches++;
            $display("%0t: frame_last expected %0b, got %0b",
                     $time, want.frame_last, rsp.frame_last);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          mf3x3_pkg::REG_WIDTH:  width_reg  = cfg_data[mf3x3_pkg::WIDTH_W-1:0];
          mf3x3_pkg::REG_HEIGHT: height_reg = cfg_data[mf3x3_pkg::HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (req_valid && req_ready) predict_request(req);
    end
    mismatch_count <= mismatches;
    results_owed   <= expected_pixels.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives the median filter with a directed 5x5 frame, then random frames,
// partial frames and flush bursts over a range of image sizes, with random
// sender gaps, receiver stalls and one long receiver hold-off.
// ---------------------------------------------------------------------------
module testbench;

  localparam int MAX_W    = 1024;
  localparam int SETTLE   = 8;
  localparam int HOLD_LEN = 200;
  localparam int LIMIT    = 200000;

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        req_valid = 1'b0;
  logic                        req_ready;
  mf3x3_pkg::req_t             req       = '0;
  logic                        rsp_valid;
  logic                        rsp_ready = 1'b0;
  mf3x3_pkg::rsp_t             rsp;
  logic                        cfg_we    = 1'b0;
  logic                        cfg_index = mf3x3_pkg::REG_WIDTH;
  logic [mf3x3_pkg::CFG_W-1:0] cfg_data  = '0;

  int mismatch_count;
  int results_owed;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_asks   = 0;
  int hold_served = 0;
  int hold_left   = 0;
  int cycles      = 0;
  int cur_w;
  int cur_h;

  median_filter_3x3 #(.MAX_WIDTH(MAX_W)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  median_filter_3x3_checker #(.MAX_WIDTH(MAX_W)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  always @(posedge clk) begin
    if (hold_asks != hold_served) begin
      hold_served <= hold_asks;
      hold_left   <= HOLD_LEN;
      rsp_ready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic offer(input logic op, input logic [7:0] value);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= {op, value};
    do @(posedge clk); while (!req_ready);
  endtask

  // Hold off until every owed result is out and the pipeline is quiet.
  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(input logic [mf3x3_pkg::CFG_W-1:0] w_raw,
                           input logic [mf3x3_pkg::CFG_W-1:0] h_raw);
    int w;
    w         = int'(w_raw[mf3x3_pkg::WIDTH_W-1:0]);
    cur_w     = (w < int'(mf3x3_pkg::WIDTH_MIN)) ? int'(mf3x3_pkg::WIDTH_MIN) :
                ((w > MAX_W) ? MAX_W : w);
    cur_h     = (h_raw < mf3x3_pkg::HEIGHT_MIN) ? int'(mf3x3_pkg::HEIGHT_MIN) : int'(h_raw);
    cfg_we    <= 1'b1;
    cfg_index <= mf3x3_pkg::REG_WIDTH;
    cfg_data  <= w_raw;
    @(posedge clk);
    cfg_index <= mf3x3_pkg::REG_HEIGHT;
    cfg_data  <= h_raw;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(input int n);
    int sent;
    int k;
    int len;
    sent = 0;
    while (sent < n) begin
      k = $urandom_range(99);
      if (k < 65) begin
        // whole frame of random pixels, then drain or run straight on
        len = cur_w * cur_h;
        if (len > n - sent) len = n - sent;
        repeat (len) offer(mf3x3_pkg::OP_PIXEL, 8'($urandom_range(255)));
        sent += len;
        if ($urandom_range(1) == 1) begin
          repeat (cur_w + 1) offer(mf3x3_pkg::OP_FLUSH, 8'($urandom_range(255)));
          sent += cur_w + 1;
        end
      end else if (k < 85) begin
        // broken frame: a few pixels, then a flush burst mid-frame
        len = $urandom_range(1, 2 * cur_w);
        repeat (len) offer(mf3x3_pkg::OP_PIXEL, 8'($urandom_range(255)));
        sent += len;
        len = $urandom_range(1, cur_w + 3);
        repeat (len) offer(mf3x3_pkg::OP_FLUSH, 8'($urandom_range(255)));
        sent += len;
      end else begin
        offer(1'($urandom_range(1)), 8'($urandom_range(255)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!req_ready) @(posedge clk);

    // one 5x5 frame: a single interior median, border pass-through elsewhere
    configure(12'd5, 12'd5);
    offer(mf3x3_pkg::OP_FLUSH, 8'hFF);
    for (int i = 0; i < 25; i++)
      offer(mf3x3_pkg::OP_PIXEL, (i % 2 == 1) ? 8'(256 - i) : 8'(i * 9));
    repeat (cur_w + 1) offer(mf3x3_pkg::OP_FLUSH, 8'h00);
    settle();

    // long receiver hold-off while the sender keeps offering
    configure(12'd4, 12'd5);
    hold_asks = hold_asks + 1;
    run_random(60);
    settle();

    configure(12'h801, 12'd1);
    idle_pct = 61;
    run_random(40);
    settle();

    configure(12'd7, 12'd6);
    idle_pct  = 0;
    stall_pct = 61;
    run_random(60);
    settle();

    configure(12'd9, 12'd4095);
    idle_pct  = 25;
    stall_pct = 25;
    run_random(60);
    settle();

    // leave many pixels owed, then shrink the width under them
    configure(12'd2047, 12'd4);
    idle_pct  = 0;
    stall_pct = 0;
    repeat (30) offer(mf3x3_pkg::OP_PIXEL, 8'($urandom_range(255)));
    settle();

    configure(12'd5, 12'd7);
    idle_pct  = 25;
    stall_pct = 25;
    run_random(60);
    settle();

    configure(12'd3, 12'd3);
    idle_pct  = 0;
    stall_pct = 61;
    run_random(40);
    settle();

    configure(12'd6, 12'd4);
    idle_pct  = 61;
    stall_pct = 0;
    run_random(30);
    repeat (cur_w + 1) offer(mf3x3_pkg::OP_FLUSH, 8'($urandom_range(255)));
    settle();

    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
